// ===== design/wavhsp_pkg.sv =====
// Shared types, codes and constants for the WAV header stream parser.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package wavhsp_pkg;

  // Byte offsets only matter up to the minimum file length, so the offset
  // counter is narrow and saturates well above the last offset it is compared with.
  localparam int unsigned OFF_W = 6;
  localparam logic [OFF_W-1:0] OFF_MAX          = {OFF_W{1'b1}};
  localparam logic [OFF_W-1:0] OFF_RIFF_END     = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_FMT_SIZE_END = OFF_W'(19);
  localparam logic [OFF_W-1:0] OFF_TAG_LO       = OFF_W'(20);
  localparam logic [OFF_W-1:0] OFF_TAG_HI       = OFF_W'(21);
  localparam logic [OFF_W-1:0] OFF_CH_LO        = OFF_W'(22);
  localparam logic [OFF_W-1:0] OFF_CH_HI        = OFF_W'(23);
  localparam logic [OFF_W-1:0] OFF_RATE_B0      = OFF_W'(24);
  localparam logic [OFF_W-1:0] OFF_RATE_B1      = OFF_W'(25);
  localparam logic [OFF_W-1:0] OFF_RATE_B2      = OFF_W'(26);
  localparam logic [OFF_W-1:0] OFF_RATE_B3      = OFF_W'(27);
  localparam logic [OFF_W-1:0] OFF_BITS_LO      = OFF_W'(34);
  localparam logic [OFF_W-1:0] OFF_BITS_HI      = OFF_W'(35);
  // A file whose last byte sits below this offset is shorter than 46 bytes.
  localparam logic [OFF_W-1:0] OFF_MIN_LAST     = OFF_W'(45);

  localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
  localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
  localparam logic [15:0] PCM_TAG        = 16'd1;
  localparam logic [31:0] ID_SIZE_BYTES  = 32'd4;

  localparam int unsigned OUT_DATA_BITS = 90;
  localparam int unsigned OUT_TDATA_W   = 96;

  typedef enum logic [8:0] {
    PH_HEAD     = 9'b0_0000_0001,
    PH_FMTBODY  = 9'b0_0000_0010,
    PH_CHUNKID  = 9'b0_0000_0100,
    PH_DATASIZE = 9'b0_0000_1000,
    PH_SKIPSIZE = 9'b0_0001_0000,
    PH_SKIPBODY = 9'b0_0010_0000,
    PH_AUDIO    = 9'b0_0100_0000,
    PH_TRAIL    = 9'b0_1000_0000,
    PH_ERR      = 9'b1_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_FMT_READY = 4'd1,
    KIND_AUDIO     = 4'd2,
    KIND_TRAILING  = 4'd3,
    KIND_NOT_RIFF  = 4'd4,
    KIND_NOT_PCM   = 4'd5,
    KIND_BAD_WIDTH = 4'd6,
    KIND_TOO_SHORT = 4'd7,
    KIND_IGNORED   = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    FMT_U8    = 2'd0,
    FMT_S16LE = 2'd1,
    FMT_S32LE = 2'd2
  } fmt_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  // Input register contents as seen by the parser.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  audio_byte;
    fmt_e        pcm_format;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [31:0] declared_data_size;
    logic        file_done;
  } result_t;

  function automatic logic width_ok(input logic [15:0] bits);
    return (bits == 16'd8) || (bits == 16'd16) || (bits == 16'd32);
  endfunction

  function automatic fmt_e map_width(input logic [15:0] bits);
    fmt_e f;
    f = FMT_U8;
    if (bits == 16'd16) f = FMT_S16LE;
    else if (bits == 16'd32) f = FMT_S32LE;
    return f;
  endfunction

endpackage

// ===== design/wav_header_stream_parser_top.sv =====
// Top level of the WAV header stream parser: stream ports and tdata packing.
// Depends on wavhsp_pkg, wavhsp_in_reg, wavhsp_parse and wavhsp_out_reg.
`timescale 1ns / 1ps

// The block parses a RIFF/WAVE file streamed in one byte per transaction and
// returns exactly one result transaction per byte, in order. It accepts one
// byte every clock cycle while the receiver keeps up, and a byte's result is
// offered from the result register after the byte passes the input register;
// the parser state between the two registers is updated once per byte. tlast on
// the input marks a file's last byte; after it the parser starts afresh on the
// next file. The header check looks for "RIFF" and PCM tag 1, captures the
// channel count, sample rate and bits per sample from their fixed offsets,
// skips unknown chunks by their declared size (no pad byte), reports the
// format when the data chunk header completes, then passes up to the declared
// number of audio bytes and marks later bytes as trailing. The first error is
// reported once and later bytes of that file come back as ignored. Either side
// may stall at any time without loss.
module wav_header_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] file_byte
  input  logic [7:0]  s_axis_tdata,
  // end_of_file
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] audio_byte, [9:8] pcm_format, [41:10] sample_rate,
  // [57:42] channel_count, [89:58] declared_data_size, [95:90] zero
  output logic [wavhsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [3:0] kind
  output logic [3:0]  m_axis_tuser,
  // file_done
  output logic        m_axis_tlast
);

  wavhsp_pkg::in_item_t in_item;
  wavhsp_pkg::stage_t   stage;
  wavhsp_pkg::result_t  result_next;
  wavhsp_pkg::result_t  result_out;
  logic                 advance;

  assign in_item.file_byte   = s_axis_tdata;
  assign in_item.end_of_file = s_axis_tlast;

  wavhsp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  wavhsp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .result_o  (result_next)
  );

  wavhsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .result_i    (result_next),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result_out)
  );

  // Fields are packed from the lowest bit up, padded with zeros to whole bytes.
  assign m_axis_tdata = {
    (wavhsp_pkg::OUT_TDATA_W - wavhsp_pkg::OUT_DATA_BITS)'(0),
    result_out.declared_data_size,
    result_out.channel_count,
    result_out.sample_rate,
    result_out.pcm_format,
    result_out.audio_byte
  };
  assign m_axis_tuser = result_out.kind;
  assign m_axis_tlast = result_out.file_done;

endmodule

// ===== design/wavhsp_in_reg.sv =====
// Input register stage of the WAV header stream parser.
// Depends on wavhsp_pkg for the item and stage types.
`timescale 1ns / 1ps

module wavhsp_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wavhsp_pkg::in_item_t in_item_i,
  input  logic                advance_i,
  output wavhsp_pkg::stage_t  stage_o
);

  logic                 valid_q, valid_d;
  wavhsp_pkg::in_item_t item_q;
  logic                 load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== design/wavhsp_parse.sv =====
// Parser state and the combinational next-state and result logic.
// Depends on wavhsp_pkg for phase codes, result kinds and tag constants.
`timescale 1ns / 1ps

module wavhsp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wavhsp_pkg::stage_t  stage_i,
  input  logic                advance_i,
  output wavhsp_pkg::result_t result_o
);

  wavhsp_pkg::phase_e            phase_q, phase_d;
  logic [wavhsp_pkg::OFF_W-1:0]  off_q, off_d;
  logic [31:0]                   shift_q, shift_d;
  logic [31:0]                   chunk_q, chunk_d;
  logic [31:0]                   data_q, data_d;
  logic [31:0]                   rate_q, rate_d;
  logic [15:0]                   chan_q, chan_d;
  logic [15:0]                   bits_q, bits_d;

  logic [7:0]  b;
  logic        eof;
  logic        not_err;
  logic [31:0] chunk_dec;
  logic [31:0] data_dec;
  wavhsp_pkg::kind_e kind;
  logic [7:0]  audio;

  assign b         = stage_i.item.file_byte;
  assign eof       = stage_i.item.end_of_file;
  assign not_err   = (phase_q != wavhsp_pkg::PH_ERR);
  assign chunk_dec = chunk_q - 32'd1;
  assign data_dec  = data_q - 32'd1;
  assign shift_d   = {b, shift_q[31:8]};

  always_comb begin
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    phase_d = phase_q;
    chunk_d = chunk_q;
    data_d  = data_q;
    kind    = wavhsp_pkg::KIND_HEADER;
    audio   = 8'h00;

    // Fixed-offset fmt fields are captured whatever the chunk scan is doing.
    if (not_err) begin
      unique case (off_q)
        wavhsp_pkg::OFF_CH_LO:   chan_d[7:0]   = b;
        wavhsp_pkg::OFF_CH_HI:   chan_d[15:8]  = b;
        wavhsp_pkg::OFF_RATE_B0: rate_d[7:0]   = b;
        wavhsp_pkg::OFF_RATE_B1: rate_d[15:8]  = b;
        wavhsp_pkg::OFF_RATE_B2: rate_d[23:16] = b;
        wavhsp_pkg::OFF_RATE_B3: rate_d[31:24] = b;
        wavhsp_pkg::OFF_BITS_LO: bits_d[7:0]   = b;
        wavhsp_pkg::OFF_BITS_HI: bits_d[15:8]  = b;
        wavhsp_pkg::OFF_TAG_LO:  bits_d        = {8'h00, b};
        default: ;
      endcase
    end

    if (not_err && (off_q == wavhsp_pkg::OFF_TAG_HI) &&
        ((bits_d | {b, 8'h00}) != wavhsp_pkg::PCM_TAG)) begin
      kind    = wavhsp_pkg::KIND_NOT_PCM;
      phase_d = wavhsp_pkg::PH_ERR;
    end else begin
      // The tag's low byte borrowed the bits register; release it.
      if (off_q == wavhsp_pkg::OFF_TAG_HI) bits_d = 16'h0000;
      unique case (phase_q)
        wavhsp_pkg::PH_HEAD: begin
          if ((off_q == wavhsp_pkg::OFF_RIFF_END) && (shift_d != wavhsp_pkg::TAG_RIFF)) begin
            kind    = wavhsp_pkg::KIND_NOT_RIFF;
            phase_d = wavhsp_pkg::PH_ERR;
          end else if (off_q == wavhsp_pkg::OFF_FMT_SIZE_END) begin
            if (shift_d != 32'd0) begin
              chunk_d = shift_d;
              phase_d = wavhsp_pkg::PH_FMTBODY;
            end else begin
              chunk_d = wavhsp_pkg::ID_SIZE_BYTES;
              phase_d = wavhsp_pkg::PH_CHUNKID;
            end
          end
        end
        wavhsp_pkg::PH_FMTBODY, wavhsp_pkg::PH_SKIPBODY: begin
          if (chunk_dec == 32'd0) begin
            chunk_d = wavhsp_pkg::ID_SIZE_BYTES;
            phase_d = wavhsp_pkg::PH_CHUNKID;
          end else begin
            chunk_d = chunk_dec;
          end
        end
        wavhsp_pkg::PH_CHUNKID: begin
          if (chunk_dec == 32'd0) begin
            chunk_d = wavhsp_pkg::ID_SIZE_BYTES;
            phase_d = (shift_d == wavhsp_pkg::TAG_DATA) ? wavhsp_pkg::PH_DATASIZE
                                                        : wavhsp_pkg::PH_SKIPSIZE;
          end else begin
            chunk_d = chunk_dec;
          end
        end
        wavhsp_pkg::PH_SKIPSIZE: begin
          if (chunk_dec == 32'd0) begin
            if (shift_d != 32'd0) begin
              chunk_d = shift_d;
              phase_d = wavhsp_pkg::PH_SKIPBODY;
            end else begin
              chunk_d = wavhsp_pkg::ID_SIZE_BYTES;
              phase_d = wavhsp_pkg::PH_CHUNKID;
            end
          end else begin
            chunk_d = chunk_dec;
          end
        end
        wavhsp_pkg::PH_DATASIZE: begin
          if (chunk_dec == 32'd0) begin
            if (!wavhsp_pkg::width_ok(bits_d)) begin
              kind    = wavhsp_pkg::KIND_BAD_WIDTH;
              phase_d = wavhsp_pkg::PH_ERR;
            end else begin
              kind    = wavhsp_pkg::KIND_FMT_READY;
              chunk_d = shift_d;
              data_d  = shift_d;
              phase_d = (shift_d != 32'd0) ? wavhsp_pkg::PH_AUDIO : wavhsp_pkg::PH_TRAIL;
            end
          end else begin
            chunk_d = chunk_dec;
          end
        end
        wavhsp_pkg::PH_AUDIO: begin
          kind   = wavhsp_pkg::KIND_AUDIO;
          audio  = b;
          data_d = data_dec;
          if (data_dec == 32'd0) phase_d = wavhsp_pkg::PH_TRAIL;
        end
        wavhsp_pkg::PH_TRAIL: begin
          kind = wavhsp_pkg::KIND_TRAILING;
        end
        wavhsp_pkg::PH_ERR: begin
          kind = wavhsp_pkg::KIND_IGNORED;
        end
        default: begin
          kind    = wavhsp_pkg::KIND_IGNORED;
          phase_d = wavhsp_pkg::PH_ERR;
        end
      endcase
    end

    // A short file is flagged on its last byte unless an error came earlier.
    if (eof && (off_q < wavhsp_pkg::OFF_MIN_LAST) && not_err) begin
      kind  = wavhsp_pkg::KIND_TOO_SHORT;
      audio = 8'h00;
    end
  end

  assign off_d = (off_q == wavhsp_pkg::OFF_MAX) ? off_q : off_q + wavhsp_pkg::OFF_W'(1);

  assign result_o.kind               = kind;
  assign result_o.audio_byte         = audio;
  assign result_o.pcm_format         = wavhsp_pkg::map_width(bits_d);
  assign result_o.sample_rate        = rate_d;
  assign result_o.channel_count      = chan_d;
  assign result_o.declared_data_size =
      ((phase_d == wavhsp_pkg::PH_AUDIO) || (phase_d == wavhsp_pkg::PH_TRAIL)) ? chunk_d : 32'd0;
  assign result_o.file_done          = eof;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhsp_pkg::PH_HEAD;
      off_q   <= '0;
      shift_q <= '0;
      chunk_q <= '0;
      data_q  <= '0;
      rate_q  <= '0;
      chan_q  <= '0;
      bits_q  <= '0;
    end else if (advance_i) begin
      if (eof) begin
        phase_q <= wavhsp_pkg::PH_HEAD;
        off_q   <= '0;
        shift_q <= '0;
        chunk_q <= '0;
        data_q  <= '0;
        rate_q  <= '0;
        chan_q  <= '0;
        bits_q  <= '0;
      end else begin
        phase_q <= phase_d;
        off_q   <= off_d;
        shift_q <= shift_d;
        chunk_q <= chunk_d;
        data_q  <= data_d;
        rate_q  <= rate_d;
        chan_q  <= chan_d;
        bits_q  <= bits_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && eof |=> (phase_q == wavhsp_pkg::PH_HEAD) && (off_q == '0))
    else $error("parser did not restart after the end of a file");

  a_audio_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wavhsp_pkg::PH_AUDIO) |-> (data_q != 32'd0))
    else $error("audio phase entered with no bytes left");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !eof && (phase_q == wavhsp_pkg::PH_ERR) |=> (phase_q == wavhsp_pkg::PH_ERR))
    else $error("error phase left before the end of the file");
`endif

endmodule

// ===== design/wavhsp_out_reg.sv =====
// Result register stage of the WAV header stream parser.
// Depends on wavhsp_pkg for the stage and result types.
`timescale 1ns / 1ps

module wavhsp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wavhsp_pkg::stage_t  stage_i,
  input  wavhsp_pkg::result_t result_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wavhsp_pkg::result_t result_o
);

  logic                valid_q, valid_d;
  wavhsp_pkg::result_t result_q;

  assign advance_o = stage_i.valid && (!valid_q || out_ready_i);
  assign valid_d   = advance_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

`ifndef SYNTHESIS
  a_audio_only_on_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (result_q.kind != wavhsp_pkg::KIND_AUDIO) |-> (result_q.audio_byte == 8'h00))
    else $error("audio byte nonzero on a non-audio result");
`endif

endmodule

// ===== test/wav_header_stream_parser_top_tb.sv =====
// Self-checking testbench for wav_header_stream_parser_top: directed byte table, then random files.
// It predicts each result from its own copy of the parser state and checks every output field.
// Depends on wavhsp_pkg and the design files.
`timescale 1ns / 1ps

module wav_header_stream_parser_top_tb;

  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned PHASE_ITEMS   = 190;
  localparam int unsigned HOLD_CYCLES   = 64;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned MIN_FILE_LEN  = 46;
  localparam logic [31:0] WAVE_ID       = 32'h4556_4157;
  localparam logic [31:0] FMT_ID        = 32'h2074_6D66;

  // One row of the directed table. When typed is set, the kind is written down
  // here and overrides the predicted kind.
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              typed;
    wavhsp_pkg::kind_e kind;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 17;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [7:0]                         s_axis_tdata;
  logic                               s_axis_tlast;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [wavhsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [3:0]                         m_axis_tuser;
  logic                               m_axis_tlast;

  // Side information that travels with the offered byte.
  logic              offer_typed;
  wavhsp_pkg::kind_e offer_kind;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_pending   = 1'b0;
  int unsigned error_count    = 0;
  int unsigned result_count   = 0;

  wavhsp_pkg::result_t results_due[$];
  logic [7:0]          file_bytes[$];

  // Parser state mirrored by the prediction.
  wavhsp_pkg::phase_e cur_phase;
  logic [31:0]        cur_offset;
  logic [31:0]        tail_word;
  logic [31:0]        part_left;
  logic [31:0]        payload_left;
  logic [31:0]        fmt_rate;
  logic [15:0]        fmt_channels;
  logic [15:0]        fmt_bits;

  wavhsp_pkg::result_t predicted;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // "RIFF" then the end mark: a good start, but far too short.
    '{8'h52, 1'b0, 1'b1, wavhsp_pkg::KIND_HEADER},
    '{8'h49, 1'b0, 1'b0, wavhsp_pkg::KIND_HEADER},
    '{8'h46, 1'b0, 1'b0, wavhsp_pkg::KIND_HEADER},
    '{8'h46, 1'b0, 1'b1, wavhsp_pkg::KIND_HEADER},
    '{8'h00, 1'b1, 1'b1, wavhsp_pkg::KIND_TOO_SHORT},
    // "RIFX": the error is reported once, later bytes are ignored, and the
    // short end no longer counts as an error of its own.
    '{8'h52, 1'b0, 1'b1, wavhsp_pkg::KIND_HEADER},
    '{8'h49, 1'b0, 1'b0, wavhsp_pkg::KIND_HEADER},
    '{8'h46, 1'b0, 1'b0, wavhsp_pkg::KIND_HEADER},
    '{8'h58, 1'b0, 1'b1, wavhsp_pkg::KIND_NOT_RIFF},
    '{8'h55, 1'b0, 1'b1, wavhsp_pkg::KIND_IGNORED},
    '{8'hFF, 1'b1, 1'b1, wavhsp_pkg::KIND_IGNORED},
    // A file of a single byte.
    '{8'hFF, 1'b1, 1'b1, wavhsp_pkg::KIND_TOO_SHORT},
    // A bad mark on the last byte: too short takes precedence.
    '{8'h00, 1'b0, 1'b1, wavhsp_pkg::KIND_HEADER},
    '{8'hFF, 1'b0, 1'b1, wavhsp_pkg::KIND_HEADER},
    '{8'h80, 1'b0, 1'b0, wavhsp_pkg::KIND_HEADER},
    '{8'h7F, 1'b1, 1'b1, wavhsp_pkg::KIND_TOO_SHORT},
    '{8'h00, 1'b1, 1'b1, wavhsp_pkg::KIND_TOO_SHORT}
  };

  wav_header_stream_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Returns the parser to the start of a file.
  function automatic void clear_parse_state();
    cur_phase    = wavhsp_pkg::PH_HEAD;
    cur_offset   = '0;
    tail_word    = '0;
    part_left    = '0;
    payload_left = '0;
    fmt_rate     = '0;
    fmt_channels = '0;
    fmt_bits     = '0;
  endfunction

  // Advances the mirrored parser by one file byte and returns the result that
  // the byte must produce.
  function automatic wavhsp_pkg::result_t parse_byte(input logic [7:0] b, input logic last);
    wavhsp_pkg::result_t r;
    logic [31:0]         off;
    wavhsp_pkg::phase_e  start_phase;
    logic                width_known;
    r           = '0;
    off         = cur_offset;
    start_phase = cur_phase;
    r.kind      = wavhsp_pkg::KIND_HEADER;
    tail_word   = {b, tail_word[31:8]};

    // The fmt fields sit at fixed offsets whatever the chunk layout says.
    if (cur_phase != wavhsp_pkg::PH_ERR) begin
      if (off == 22) fmt_channels[7:0] = b;
      else if (off == 23) fmt_channels[15:8] = b;
      else if (off >= 24 && off <= 27) fmt_rate[8*(off-24) +: 8] = b;
      else if (off == 34) fmt_bits[7:0] = b;
      else if (off == 35) fmt_bits[15:8] = b;
      else if (off == 20) fmt_bits = {8'h00, b};
    end

    if (cur_phase != wavhsp_pkg::PH_ERR && off == 21 &&
        (fmt_bits | {b, 8'h00}) != wavhsp_pkg::PCM_TAG) begin
      r.kind    = wavhsp_pkg::KIND_NOT_PCM;
      cur_phase = wavhsp_pkg::PH_ERR;
    end else begin
      // The tag borrowed the bits register; it is cleared once checked.
      if (off == 21) fmt_bits = '0;
      case (cur_phase)
        wavhsp_pkg::PH_HEAD: begin
          if (off == 3 && tail_word != wavhsp_pkg::TAG_RIFF) begin
            r.kind    = wavhsp_pkg::KIND_NOT_RIFF;
            cur_phase = wavhsp_pkg::PH_ERR;
          end else if (off == 19) begin
            part_left = tail_word;
            if (part_left != 0) begin
              cur_phase = wavhsp_pkg::PH_FMTBODY;
            end else begin
              cur_phase = wavhsp_pkg::PH_CHUNKID;
              part_left = wavhsp_pkg::ID_SIZE_BYTES;
            end
          end
        end
        wavhsp_pkg::PH_FMTBODY, wavhsp_pkg::PH_SKIPBODY: begin
          part_left = part_left - 1;
          if (part_left == 0) begin
            cur_phase = wavhsp_pkg::PH_CHUNKID;
            part_left = wavhsp_pkg::ID_SIZE_BYTES;
          end
        end
        wavhsp_pkg::PH_CHUNKID: begin
          part_left = part_left - 1;
          if (part_left == 0) begin
            part_left = wavhsp_pkg::ID_SIZE_BYTES;
            cur_phase = (tail_word == wavhsp_pkg::TAG_DATA) ? wavhsp_pkg::PH_DATASIZE
                                                            : wavhsp_pkg::PH_SKIPSIZE;
          end
        end
        wavhsp_pkg::PH_SKIPSIZE: begin
          part_left = part_left - 1;
          if (part_left == 0) begin
            part_left = tail_word;
            if (part_left != 0) begin
              cur_phase = wavhsp_pkg::PH_SKIPBODY;
            end else begin
              cur_phase = wavhsp_pkg::PH_CHUNKID;
              part_left = wavhsp_pkg::ID_SIZE_BYTES;
            end
          end
        end
        wavhsp_pkg::PH_DATASIZE: begin
          part_left = part_left - 1;
          if (part_left == 0) begin
            width_known = (fmt_bits == 16'd8) || (fmt_bits == 16'd16) || (fmt_bits == 16'd32);
            if (!width_known) begin
              r.kind    = wavhsp_pkg::KIND_BAD_WIDTH;
              cur_phase = wavhsp_pkg::PH_ERR;
            end else begin
              r.kind       = wavhsp_pkg::KIND_FMT_READY;
              part_left    = tail_word;
              payload_left = tail_word;
              cur_phase    = (payload_left != 0) ? wavhsp_pkg::PH_AUDIO : wavhsp_pkg::PH_TRAIL;
            end
          end
        end
        wavhsp_pkg::PH_AUDIO: begin
          r.kind       = wavhsp_pkg::KIND_AUDIO;
          r.audio_byte = b;
          payload_left = payload_left - 1;
          if (payload_left == 0) cur_phase = wavhsp_pkg::PH_TRAIL;
        end
        wavhsp_pkg::PH_TRAIL: begin
          r.kind = wavhsp_pkg::KIND_TRAILING;
        end
        default: begin
          r.kind    = wavhsp_pkg::KIND_IGNORED;
          cur_phase = wavhsp_pkg::PH_ERR;
        end
      endcase
    end

    if (last && off < MIN_FILE_LEN - 1 && start_phase != wavhsp_pkg::PH_ERR) begin
      r.kind       = wavhsp_pkg::KIND_TOO_SHORT;
      r.audio_byte = '0;
    end

    case (fmt_bits)
      16'd16:  r.pcm_format = wavhsp_pkg::FMT_S16LE;
      16'd32:  r.pcm_format = wavhsp_pkg::FMT_S32LE;
      default: r.pcm_format = wavhsp_pkg::FMT_U8;
    endcase
    r.sample_rate        = fmt_rate;
    r.channel_count      = fmt_channels;
    r.declared_data_size =
        (cur_phase == wavhsp_pkg::PH_AUDIO || cur_phase == wavhsp_pkg::PH_TRAIL) ? part_left : '0;
    r.file_done          = last;

    if (cur_offset != 32'hFFFF_FFFF) cur_offset = cur_offset + 1;
    if (last) clear_parse_state();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t: mismatch in result %0d, %s: got %0h, want %0h",
             $realtime, result_count, what, got, want);
  endtask

  // Offers one byte and returns at the clock edge where it is taken.
  task automatic offer_byte(input logic [7:0] data, input logic last, input logic typed,
                            input wavhsp_pkg::kind_e kind);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    offer_typed   <= typed;
    offer_kind    <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_half(input logic [15:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endtask

  // Every accepted byte adds its expected result to the queue.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted = parse_byte(s_axis_tdata, s_axis_tlast);
      if (offer_typed) predicted.kind = offer_kind;
      results_due.push_back(predicted);
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    wavhsp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(m_axis_tuser), '0);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
        if (m_axis_tdata[7:0] !== want.audio_byte)
          report_mismatch("audio_byte", 32'(m_axis_tdata[7:0]), 32'(want.audio_byte));
        if (m_axis_tdata[9:8] !== want.pcm_format)
          report_mismatch("pcm_format", 32'(m_axis_tdata[9:8]), 32'(want.pcm_format));
        if (m_axis_tdata[41:10] !== want.sample_rate)
          report_mismatch("sample_rate", m_axis_tdata[41:10], want.sample_rate);
        if (m_axis_tdata[57:42] !== want.channel_count)
          report_mismatch("channel_count", 32'(m_axis_tdata[57:42]), 32'(want.channel_count));
        if (m_axis_tdata[89:58] !== want.declared_data_size)
          report_mismatch("declared_data_size", m_axis_tdata[89:58], want.declared_data_size);
        if (m_axis_tlast !== want.file_done)
          report_mismatch("file_done", 32'(m_axis_tlast), 32'(want.file_done));
      end
      result_count++;
    end
  end

  // The receiver stalls at random, and once holds off for a long stretch so
  // that the parser fills up and pushes back on its input.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_pending = 1'b0;
      end
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned pick, r, fsz, skip_len, audio_n, trail_n, start, random_sent;
    logic [31:0] dsz;
    logic [15:0] bits;

    clear_parse_state();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    offer_typed   <= 1'b0;
    offer_kind    <= wavhsp_pkg::KIND_HEADER;
    rst_ni        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < N_DIRECTED; k++) begin
      offer_byte(directed_rows[k].data, directed_rows[k].last, directed_rows[k].typed,
                 directed_rows[k].kind);
    end

    // Random files, mostly well formed. The long receiver hold comes first,
    // while the sender offers a byte every cycle.
    hold_pending = 1'b1;
    random_sent  = 0;
    while (random_sent < RANDOM_ITEMS) begin
      file_bytes.delete();
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0:       bits = 16'd8;
        1:       bits = 16'd16;
        2:       bits = 16'd32;
        default: bits = 16'($urandom);
      endcase
      if ($urandom_range(99) < 80 && bits > 16'd32) bits = 16'd16;

      if (pick < 12) begin
        // Noise, sometimes behind a valid mark.
        if ($urandom_range(1) != 0) put_word(wavhsp_pkg::TAG_RIFF);
        repeat ($urandom_range(1, 50)) file_bytes.push_back(8'($urandom));
      end else begin
        put_word(($urandom_range(99) < 8) ? $urandom : wavhsp_pkg::TAG_RIFF);
        put_word($urandom);
        put_word(WAVE_ID);
        put_word(FMT_ID);
        // A fmt chunk of 8 bytes puts the data size over the bits field, so
        // the width check runs on bits taken from the size itself.
        r = $urandom_range(99);
        if (pick < 22) fsz = 8;
        else if (r < 60) fsz = 16;
        else if (r < 70) fsz = 18;
        else if (r < 85) fsz = $urandom_range(0, 15);
        else fsz = $urandom_range(19, 40);
        put_word(fsz);

        start = file_bytes.size();
        put_half(($urandom_range(99) < 6) ? 16'($urandom) : wavhsp_pkg::PCM_TAG);
        put_half(($urandom_range(1) != 0) ? 16'($urandom_range(1, 2)) : 16'($urandom));
        put_word(($urandom_range(1) != 0) ? 32'd48000 : $urandom);
        put_word($urandom);
        put_half(16'($urandom));
        put_half(bits);
        while (file_bytes.size() < start + fsz) file_bytes.push_back(8'($urandom));
        while (file_bytes.size() > start + fsz) void'(file_bytes.pop_back());

        if (pick < 22) begin
          dsz     = {bits, 16'($urandom_range(0, 30))};
          audio_n = $urandom_range(0, 12);
          trail_n = 0;
        end else begin
          // Unknown chunks to skip, each with a random id and a small body.
          repeat ($urandom_range(0, 2)) begin
            put_word($urandom);
            skip_len = $urandom_range(0, 8);
            put_word(skip_len);
            repeat (skip_len) file_bytes.push_back(8'($urandom));
          end
          r = $urandom_range(99);
          if (r < 8) dsz = $urandom;
          else if (r < 16) dsz = '0;
          else if (r < 22) dsz = $urandom_range(40, 90);
          else dsz = $urandom_range(1, 16);
          if (dsz > 90) audio_n = $urandom_range(0, 12);
          else if ($urandom_range(99) < 15) audio_n = $urandom_range(0, dsz);
          else audio_n = dsz;
          trail_n = (audio_n == dsz) ? $urandom_range(0, 6) : 0;
        end
        put_word(wavhsp_pkg::TAG_DATA);
        put_word(dsz);
        repeat (audio_n + trail_n) file_bytes.push_back(8'($urandom));
      end

      // Broken files: one byte overwritten, or the file cut short.
      r = $urandom_range(99);
      if (r < 8) file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
      else if (r < 14) begin
        start = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > start) void'(file_bytes.pop_back());
      end

      for (int k = 0; k < file_bytes.size(); k++) begin
        offer_byte(file_bytes[k], k == file_bytes.size() - 1, 1'b0, wavhsp_pkg::KIND_HEADER);
        random_sent++;
        // Idling modes rotate through the run: none, sender only, receiver
        // only, then both sides.
        case ((random_sent / PHASE_ITEMS) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
          default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/wavhsp_pkg.sv
design/wavhsp_in_reg.sv
design/wavhsp_parse.sv
design/wavhsp_out_reg.sv
design/wav_header_stream_parser_top.sv
test/wav_header_stream_parser_top_tb.sv
